/* hw/rtl/pn2d_pkg.sv */
package pn2d_pkg;

  // Default number of fraction bits in coordinates and in the noise value.
  localparam int FRAC_BITS_DEF = 16;
  // Integer bits of a coordinate; the grid wraps at 2**CELL_BITS.
  localparam int CELL_BITS = 8;
  // Low bits of a corner hash that select the gradient.
  localparam int HASH_BITS = 3;

  // Depth of the queue between the hash front end and the arithmetic back end.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [HASH_BITS-1:0] h00;
    logic [HASH_BITS-1:0] h10;
    logic [HASH_BITS-1:0] h01;
    logic [HASH_BITS-1:0] h11;
  } pn2d_hash_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } pn2d_qstat_t;

  localparam logic [CELL_BITS-1:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

  function automatic logic [CELL_BITS-1:0] pn2d_perm(input logic [CELL_BITS-1:0] idx);
    return PERM_ROM[idx];
  endfunction

endpackage

/* hw/rtl/pn2d_channels.sv */
interface pn2d_coord_if #(
  parameter int COORD_W = pn2d_pkg::FRAC_BITS_DEF + pn2d_pkg::CELL_BITS
);
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface pn2d_noise_if #(
  parameter int NOISE_W = pn2d_pkg::FRAC_BITS_DEF + 3
);
  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

/* hw/rtl/pn2d_front.sv */
module pn2d_front #(
  parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [FRAC_BITS+pn2d_pkg::CELL_BITS-1:0]   x_coord,
  input  logic [FRAC_BITS+pn2d_pkg::CELL_BITS-1:0]   y_coord,
  input  pn2d_pkg::pn2d_qstat_t                      q_stat,
  output logic                                       q_push,
  output logic [FRAC_BITS-1:0]                       q_fx,
  output logic [FRAC_BITS-1:0]                       q_fy,
  output pn2d_pkg::pn2d_hash_t                       q_hash
);
  import pn2d_pkg::*;

  localparam int F = FRAC_BITS;

  logic [2:0] vld_r;
  logic       adv;

  logic [CELL_BITS-1:0] cx, cy, cx1;
  logic [CELL_BITS-1:0] s1_a_r, s1_b_r;
  logic [F-1:0]         s1_fx_r, s1_fy_r;
  logic [CELL_BITS-1:0] s2_ra_r, s2_ra1_r, s2_rb_r, s2_rb1_r;
  logic [F-1:0]         s2_fx_r, s2_fy_r;
  logic [CELL_BITS-1:0] p_aa, p_ab, p_ba, p_bb;
  pn2d_hash_t           s3_hash_r;
  logic [F-1:0]         s3_fx_r, s3_fy_r;

  // The three stages move together; they stop only when the last one
  // holds a beat that the queue cannot take.
  assign adv      = !vld_r[2] || !q_stat.full;
  assign in_ready = adv;
  assign q_push   = vld_r[2] && !q_stat.full;
  assign q_fx     = s3_fx_r;
  assign q_fy     = s3_fy_r;
  assign q_hash   = s3_hash_r;

  assign cx  = x_coord[F+CELL_BITS-1:F];
  assign cy  = y_coord[F+CELL_BITS-1:F];
  assign cx1 = cx + 1'b1;

  assign p_aa = pn2d_perm(s2_ra_r);
  assign p_ab = pn2d_perm(s2_ra1_r);
  assign p_ba = pn2d_perm(s2_rb_r);
  assign p_bb = pn2d_perm(s2_rb1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a_r    <= pn2d_perm(cx) + cy;
      s1_b_r    <= pn2d_perm(cx1) + cy;
      s1_fx_r   <= x_coord[F-1:0];
      s1_fy_r   <= y_coord[F-1:0];

      s2_ra_r   <= pn2d_perm(s1_a_r);
      s2_ra1_r  <= pn2d_perm(s1_a_r + 1'b1);
      s2_rb_r   <= pn2d_perm(s1_b_r);
      s2_rb1_r  <= pn2d_perm(s1_b_r + 1'b1);
      s2_fx_r   <= s1_fx_r;
      s2_fy_r   <= s1_fy_r;

      s3_hash_r.h00 <= p_aa[HASH_BITS-1:0];
      s3_hash_r.h01 <= p_ab[HASH_BITS-1:0];
      s3_hash_r.h10 <= p_ba[HASH_BITS-1:0];
      s3_hash_r.h11 <= p_bb[HASH_BITS-1:0];
      s3_fx_r       <= s2_fx_r;
      s3_fy_r       <= s2_fy_r;
    end
  end

endmodule

/* hw/rtl/pn2d_queue.sv */
module pn2d_queue #(
  parameter int DATA_W = 2 * pn2d_pkg::FRAC_BITS_DEF + $bits(pn2d_pkg::pn2d_hash_t)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  logic [DATA_W-1:0]     push_data,
  input  logic                  pop,
  output logic [DATA_W-1:0]     head_data,
  output pn2d_pkg::pn2d_qstat_t stat
);
  import pn2d_pkg::*;

  logic [DATA_W-1:0] mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head_data  = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/pn2d_back.sv */
module pn2d_back #(
  parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pn2d_pkg::pn2d_qstat_t       q_stat,
  input  logic [FRAC_BITS-1:0]        q_fx,
  input  logic [FRAC_BITS-1:0]        q_fy,
  input  pn2d_pkg::pn2d_hash_t        q_hash,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS+2:0] noise_value
);
  import pn2d_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int NST  = 7;
  localparam int DXW  = F + 2;   // corner offsets, [-1, 1)
  localparam int GW   = F + 3;   // gradient terms, [-3, 3]
  localparam int DW   = F + 4;   // differences of gradient terms and lerp values
  localparam int UW   = F + 2;   // faded fractions, [0, 1]
  localparam int IW   = F + 5;   // inner fade polynomial, up to 10
  localparam int MW   = F + 1 + IW;
  localparam int LPW  = UW + DW;
  localparam int OW   = F + 3;

  localparam logic signed [DXW-1:0] ONE_DX     = DXW'(1) << F;
  localparam logic signed [IW-1:0]  FIFTEEN_FX = IW'(15) << F;
  localparam logic signed [IW-1:0]  TEN_FX     = IW'(10) << F;

  function automatic logic signed [GW-1:0] grad(
    input logic [HASH_BITS-1:0]    h,
    input logic signed [DXW-1:0]   dx,
    input logic signed [DXW-1:0]   dy
  );
    logic signed [GW-1:0] gu;
    logic signed [GW-1:0] gv;
    gu = h[2] ? GW'(dy) : GW'(dx);
    gv = h[2] ? GW'(dx) : GW'(dy);
    gv = gv <<< 1;
    if (h[0]) gu = -gu;
    if (h[1]) gv = -gv;
    return gu + gv;
  endfunction

  logic [NST-1:0] vld_r;
  logic           adv;

  // Stage 1 combinational terms, taken from the queue head.
  logic signed [DXW-1:0] dx0, dx1, dy0, dy1;
  logic signed [GW-1:0]  g00, g10, g01, g11;
  logic [2*F-1:0]        t2x_p, t2y_p;
  logic signed [IW-1:0]  sx_m15, sy_m15;
  logic signed [MW-1:0]  mx_p, my_p;

  logic [F-1:0]          s1_t2x_r, s1_t2y_r, s1_fx_r, s1_fy_r;
  logic signed [IW-1:0]  s1_ix_r, s1_iy_r;
  logic signed [GW-1:0]  s1_g00_r, s1_g01_r;
  logic signed [DW-1:0]  s1_dlo_r, s1_dhi_r;

  logic [2*F-1:0]        t3x_p, t3y_p;
  logic [F-1:0]          s2_t3x_r, s2_t3y_r;
  logic signed [IW-1:0]  s2_ix_r, s2_iy_r;
  logic signed [GW-1:0]  s2_g00_r, s2_g01_r;
  logic signed [DW-1:0]  s2_dlo_r, s2_dhi_r;

  logic signed [MW-1:0]  ux_p, uy_p;
  logic signed [UW-1:0]  s3_u_r, s3_v_r;
  logic signed [GW-1:0]  s3_g00_r, s3_g01_r;
  logic signed [DW-1:0]  s3_dlo_r, s3_dhi_r;

  logic signed [LPW-1:0] plo_p, phi_p;
  logic signed [DW-1:0]  s4_plo_r, s4_phi_r;
  logic signed [GW-1:0]  s4_g00_r, s4_g01_r;
  logic signed [UW-1:0]  s4_v_r;

  logic signed [DW-1:0]  lo_w, hi_w;
  logic signed [DW-1:0]  s5_lo_r, s5_dv_r;
  logic signed [UW-1:0]  s5_v_r;

  logic signed [LPW-1:0] pv_p;
  logic signed [DW-1:0]  s6_lo_r, s6_pv_r;

  logic signed [DW-1:0]  res_w;
  logic [OW-1:0]         s7_res_r;

  // One stall signal for the whole pipe; the last stage is the output register.
  assign adv         = !vld_r[NST-1] || out_ready;
  assign q_pop       = adv && !q_stat.empty;
  assign out_valid   = vld_r[NST-1];
  assign noise_value = $signed(s7_res_r);

  assign dx0 = $signed({2'b00, q_fx});
  assign dy0 = $signed({2'b00, q_fy});
  assign dx1 = dx0 - ONE_DX;
  assign dy1 = dy0 - ONE_DX;
  assign g00 = grad(q_hash.h00, dx0, dy0);
  assign g10 = grad(q_hash.h10, dx1, dy0);
  assign g01 = grad(q_hash.h01, dx0, dy1);
  assign g11 = grad(q_hash.h11, dx1, dy1);

  assign t2x_p  = (2*F)'(q_fx) * (2*F)'(q_fx);
  assign t2y_p  = (2*F)'(q_fy) * (2*F)'(q_fy);
  assign sx_m15 = $signed(IW'({q_fx, 2'b00}) + IW'({q_fx, 1'b0})) - FIFTEEN_FX;
  assign sy_m15 = $signed(IW'({q_fy, 2'b00}) + IW'({q_fy, 1'b0})) - FIFTEEN_FX;
  assign mx_p   = MW'($signed({1'b0, q_fx})) * MW'(sx_m15);
  assign my_p   = MW'($signed({1'b0, q_fy})) * MW'(sy_m15);

  assign t3x_p = (2*F)'(s1_t2x_r) * (2*F)'(s1_fx_r);
  assign t3y_p = (2*F)'(s1_t2y_r) * (2*F)'(s1_fy_r);

  assign ux_p = MW'($signed({1'b0, s2_t3x_r})) * MW'(s2_ix_r);
  assign uy_p = MW'($signed({1'b0, s2_t3y_r})) * MW'(s2_iy_r);

  assign plo_p = LPW'(s3_u_r) * LPW'(s3_dlo_r);
  assign phi_p = LPW'(s3_u_r) * LPW'(s3_dhi_r);

  assign lo_w = DW'(s4_g00_r) + s4_plo_r;
  assign hi_w = DW'(s4_g01_r) + s4_phi_r;

  assign pv_p = LPW'(s5_v_r) * LPW'(s5_dv_r);

  assign res_w = s6_lo_r + s6_pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], q_pop};
    end
  end

  // Arithmetic right shifts of the products give the floor that truncation calls for.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_t2x_r <= t2x_p[2*F-1:F];
      s1_t2y_r <= t2y_p[2*F-1:F];
      s1_fx_r  <= q_fx;
      s1_fy_r  <= q_fy;
      s1_ix_r  <= IW'(mx_p >>> F) + TEN_FX;
      s1_iy_r  <= IW'(my_p >>> F) + TEN_FX;
      s1_g00_r <= g00;
      s1_g01_r <= g01;
      s1_dlo_r <= DW'(g10) - DW'(g00);
      s1_dhi_r <= DW'(g11) - DW'(g01);

      s2_t3x_r <= t3x_p[2*F-1:F];
      s2_t3y_r <= t3y_p[2*F-1:F];
      s2_ix_r  <= s1_ix_r;
      s2_iy_r  <= s1_iy_r;
      s2_g00_r <= s1_g00_r;
      s2_g01_r <= s1_g01_r;
      s2_dlo_r <= s1_dlo_r;
      s2_dhi_r <= s1_dhi_r;

      s3_u_r   <= UW'(ux_p >>> F);
      s3_v_r   <= UW'(uy_p >>> F);
      s3_g00_r <= s2_g00_r;
      s3_g01_r <= s2_g01_r;
      s3_dlo_r <= s2_dlo_r;
      s3_dhi_r <= s2_dhi_r;

      s4_plo_r <= DW'(plo_p >>> F);
      s4_phi_r <= DW'(phi_p >>> F);
      s4_g00_r <= s3_g00_r;
      s4_g01_r <= s3_g01_r;
      s4_v_r   <= s3_v_r;

      s5_lo_r  <= lo_w;
      s5_dv_r  <= hi_w - lo_w;
      s5_v_r   <= s4_v_r;

      s6_lo_r  <= s5_lo_r;
      s6_pv_r  <= DW'(pv_p >>> F);

      s7_res_r <= res_w[OW-1:0];
    end
  end

endmodule

/* hw/rtl/perlin_noise_2d_unit.sv */
// Two-dimensional gradient noise, one point per clock while the queue is not full. Each
// coordinate carries 8 integer bits (the grid wraps at 256) above FRAC_BITS fraction bits,
// and the result is a signed value with FRAC_BITS fraction bits in -3.0 .. +3.0. A
// three-stage front end hashes the cell corners through the permutation ROM and hands the
// fractions and corner hashes to a four-entry queue; a seven-stage back end evaluates the
// fade curve, the corner gradients and the bilinear blend, at most one multiplier rank per
// stage, and its last stage is the output register. A beat runs through the front-end
// stages, the queue and the back-end stages in turn. A stall on the output freezes the back
// end; the front end keeps accepting until the queue is full.
module perlin_noise_2d_unit #(
  parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  pn2d_coord_if.sink          in_ch,
  pn2d_noise_if.source        out_ch
);
  import pn2d_pkg::*;

  localparam int QW = 2 * FRAC_BITS + $bits(pn2d_hash_t);

  pn2d_qstat_t          q_stat;
  logic                 q_push;
  logic                 q_pop;
  logic [FRAC_BITS-1:0] f_fx, f_fy, h_fx, h_fy;
  pn2d_hash_t           f_hash, h_hash;
  logic [QW-1:0]        q_head;

  pn2d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .x_coord  (in_ch.x_coord),
    .y_coord  (in_ch.y_coord),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_fx     (f_fx),
    .q_fy     (f_fy),
    .q_hash   (f_hash)
  );

  pn2d_queue #(.DATA_W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_fx, f_fy, f_hash}),
    .pop       (q_pop),
    .head_data (q_head),
    .stat      (q_stat)
  );

  assign {h_fx, h_fy, h_hash} = q_head;

  pn2d_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_stat      (q_stat),
    .q_fx        (h_fx),
    .q_fy        (h_fy),
    .q_hash      (h_hash),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .noise_value (out_ch.noise_value)
  );

  a_q_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  a_q_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  a_q_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue count did not follow a write");

  a_q_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && !q_push) |=> (q_stat.count == $past(q_stat.count) - 1'b1))
    else $error("queue count did not follow a read");

endmodule

/* test/perlin_noise_2d_unit_test.sv */
`timescale 1ns / 1ps

module perlin_noise_2d_unit_test;
  import pn2d_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int COORD_W = FB + CELL_BITS;
  localparam int NOISE_W = FB + 3;
  localparam int RANDOM_POINTS = 650;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_START = 200;
  localparam int HOLD_POINTS = 60;

  typedef struct {
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic signed [NOISE_W-1:0] noise;
  } noise_expect_t;

  class noise_scoreboard;
    noise_expect_t expected_q[$];
    int            errors;

    function new();
      errors = 0;
    endfunction

    // Product of two fixed-point values, floored back to FB fraction bits.
    function automatic longint fx_mul(longint a, longint b);
      return (a * b) >>> FB;
    endfunction

    function automatic longint fade(longint t);
      longint t3;
      longint inner;
      t3 = fx_mul(fx_mul(t, t), t);
      inner = fx_mul(t, t * 6 - 15 * (longint'(1) << FB)) + 10 * (longint'(1) << FB);
      return fx_mul(t3, inner);
    endfunction

    function automatic longint corner_term(logic [7:0] hash, longint dx, longint dy);
      logic [2:0] h;
      longint     u;
      longint     v;
      longint     a;
      longint     b;
      h = hash[2:0];
      u = h[2] ? dy : dx;
      v = h[2] ? dx : dy;
      a = h[0] ? -u : u;
      b = h[1] ? -2 * v : 2 * v;
      return a + b;
    endfunction

    function automatic logic signed [NOISE_W-1:0] noise_at(logic [COORD_W-1:0] x,
                                                           logic [COORD_W-1:0] y);
      longint one;
      longint fx;
      longint fy;
      longint su;
      longint sv;
      longint lo;
      longint hi;
      longint res;
      int     cx;
      int     cy;
      int     a;
      int     b;
      logic [7:0] haa;
      logic [7:0] hab;
      logic [7:0] hba;
      logic [7:0] hbb;
      one = longint'(1) << FB;
      cx = int'(x[FB +: CELL_BITS]);
      cy = int'(y[FB +: CELL_BITS]);
      fx = longint'(x[FB-1:0]);
      fy = longint'(y[FB-1:0]);
      su = fade(fx);
      sv = fade(fy);
      // Indexes into the permutation table are taken modulo the ROM size.
      a = int'(PERM_ROM[cx]) + cy;
      b = int'(PERM_ROM[(cx + 1) % 256]) + cy;
      haa = PERM_ROM[PERM_ROM[a % 256]];
      hab = PERM_ROM[PERM_ROM[(a + 1) % 256]];
      hba = PERM_ROM[PERM_ROM[b % 256]];
      hbb = PERM_ROM[PERM_ROM[(b + 1) % 256]];
      lo = corner_term(haa, fx, fy);
      lo = lo + fx_mul(su, corner_term(hba, fx - one, fy) - lo);
      hi = corner_term(hab, fx, fy - one);
      hi = hi + fx_mul(su, corner_term(hbb, fx - one, fy - one) - hi);
      res = lo + fx_mul(sv, hi - lo);
      return res[NOISE_W-1:0];
    endfunction

    function void note_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      noise_expect_t e;
      e.x = x;
      e.y = y;
      e.noise = noise_at(x, y);
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_noise(logic signed [NOISE_W-1:0] got);
      noise_expect_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("noise beat %0d arrived with no point pending", got));
      end else begin
        e = expected_q.pop_front();
        if (got !== e.noise)
          report($sformatf("point x=%06h y=%06h: noise %0d, expected %0d",
                           e.x, e.y, got, e.noise));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   hold_req;
  bit   hold_done;

  pn2d_coord_if #(.COORD_W(COORD_W)) in_if ();
  pn2d_noise_if #(.NOISE_W(NOISE_W)) out_if ();

  perlin_noise_2d_unit #(.FRAC_BITS(FB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  noise_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  function automatic logic [COORD_W-1:0] random_coord();
    logic [COORD_W-1:0] c;
    int                 mode;
    c = COORD_W'($urandom);
    mode = $urandom_range(0, 9);
    case (mode)
      0: c[FB-1:0] = '0;
      1: c[FB-1:0] = {FB{1'b1}} - FB'($urandom_range(0, 15));
      2: c[FB-1:0] = FB'($urandom_range(0, 15));
      3: c[FB +: CELL_BITS] = {CELL_BITS{1'b1}};
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.x_coord <= x;
    in_if.y_coord <= y;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Accepted beats on both channels, sampled before this edge's updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.note_point(in_if.x_coord, in_if.y_coord);
      if (out_if.valid && out_if.ready)
        sb.check_noise(out_if.noise_value);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("perlin_noise_2d_unit_test NOT OK");
    $finish;
  end

  // Result side: bursts of ready with random stalls, plus one long hold-off.
  initial begin
    int stall;
    int burst;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        stall = idle_gap();
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
        out_if.ready <= 1'b1;
        repeat (burst) @(posedge clk);
      end
    end
  end

  initial begin
    bit quiet;
    int gap;
    hold_req = 1'b0;
    quiet = 1'b0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.x_coord <= '0;
    in_if.y_coord <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Field extremes, grid lines, wrap at the last cell and fractions near 0 and 1.
    send_point(24'h000000, 24'h000000, 0);
    send_point(24'hFFFFFF, 24'hFFFFFF, 0);
    send_point(24'hFFFFFF, 24'h000000, 0);
    send_point(24'h000000, 24'hFFFFFF, 0);
    send_point(24'h010000, 24'h020000, 0);
    send_point(24'hFF0000, 24'hFF0000, 0);
    send_point(24'h008000, 24'h008000, 0);
    send_point(24'h00FFFF, 24'h000001, 0);
    send_point(24'h000001, 24'h00FFFF, 0);
    send_point(24'h7F8000, 24'h804000, 0);
    send_point(24'hFFFFFF, 24'h123456, 0);
    send_point(24'hFF8000, 24'h00C000, 2);
    // Grid points across several cells so that the corner hashes cover all gradients.
    for (int i = 0; i < 8; i++)
      send_point(COORD_W'(i * 29) << FB, COORD_W'((i * 37 + 11) % 256) << FB, 0);

    for (int n = 0; n < RANDOM_POINTS; n++) begin
      if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n == HOLD_START) hold_req = 1'b1;
      if (quiet || (n >= HOLD_START && n < HOLD_START + HOLD_POINTS))
        gap = 0;
      else
        gap = idle_gap();
      send_point(random_coord(), random_coord(), gap);
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("perlin_noise_2d_unit_test OK");
    else
      $display("perlin_noise_2d_unit_test NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pn2d_pkg.sv
hw/rtl/pn2d_channels.sv
hw/rtl/pn2d_front.sv
hw/rtl/pn2d_queue.sv
hw/rtl/pn2d_back.sv
hw/rtl/perlin_noise_2d_unit.sv
test/perlin_noise_2d_unit_test.sv
